### hw/rtl/ilist_pkg.sv
`default_nettype none

package ilist_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned AT_W = 13;
  localparam int unsigned TREE_RADIX_LOG = 4;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_TAIL   = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic            ins;
    logic            del;
    logic [AT_W-1:0] at;
    logic [AT_W-1:0] rd_at;
  } cell_ctrl_t;

  function automatic int tree_latency(input int levels);
    int n;
    n = 0;
    for (int d = 0; d < levels; d++) begin
      if (((levels - d) % TREE_RADIX_LOG == 0) || (d == 0)) begin
        n++;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ilist_cell.sv
`default_nettype none

module ilist_cell #(
  parameter int INDEX = 0
) (
  input  wire                              clk_i,
  input  ilist_pkg::cell_ctrl_t            ctrl_i,
  input  wire  [ilist_pkg::DATA_W-1:0]     value_i,
  input  wire  [ilist_pkg::DATA_W-1:0]     left_i,
  input  wire  [ilist_pkg::DATA_W-1:0]     right_i,
  output logic [ilist_pkg::DATA_W-1:0]     data_o,
  output logic [ilist_pkg::DATA_W-1:0]     rd_o
);

  localparam logic [ilist_pkg::AT_W-1:0] IDX = ilist_pkg::AT_W'(INDEX);

  logic [ilist_pkg::DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      if (IDX == ctrl_i.at) begin
        data_q <= value_i;
      end else if (IDX > ctrl_i.at) begin
        data_q <= left_i;
      end
    end else if (ctrl_i.del && (IDX >= ctrl_i.at)) begin
      data_q <= right_i;
    end
  end

  assign data_o = data_q;
  assign rd_o   = (IDX == ctrl_i.rd_at) ? data_q : '0;

endmodule

`default_nettype wire

### hw/rtl/ilist_rd_tree.sv
`default_nettype none

module ilist_rd_tree #(
  parameter int N = 256
) (
  input  wire                           clk_i,
  input  wire  [ilist_pkg::DATA_W-1:0]  leaf_i [N],
  output logic [ilist_pkg::DATA_W-1:0]  root_o
);

  localparam int LEVELS = $clog2(N);
  localparam int NP = 1 << LEVELS;

  wire [ilist_pkg::DATA_W-1:0] node [1:2*NP-1];

  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign node[NP+i] = leaf_i[i];
    end else begin : g_pad
      assign node[NP+i] = '0;
    end
  end

  for (genvar k = 1; k < NP; k++) begin : g_node
    localparam int D = $clog2(k + 1) - 1;
    if (((LEVELS - D) % ilist_pkg::TREE_RADIX_LOG == 0) || (D == 0)) begin : g_reg
      logic [ilist_pkg::DATA_W-1:0] node_q;
      always_ff @(posedge clk_i) begin
        node_q <= node[2*k] | node[2*k+1];
      end
      assign node[k] = node_q;
    end else begin : g_comb
      assign node[k] = node[2*k] | node[2*k+1];
    end
  end

  assign root_o = node[1];

endmodule

`default_nettype wire

### hw/rtl/indexed_list_insert_delete_get_unit.sv
// Positional list of signed 32-bit entries: get, insert, delete by index, append.
// Input channel: in_valid_i/in_stall_o with req_type_i, position_i, item_value_i.
// Output channel: out_valid_o/out_stall_i with read_value_o, status_o, entry_count_o.
// Every transaction on the input gives exactly one transaction on the output.
// Entries live in a row of cells; an insert or delete moves every entry beyond
// the position by one cell at once, so those requests (and every out-of-range
// or refused request) are accepted at one per cycle unless the output stalls,
// and their result is in the output register in the cycle after acceptance.
// An in-range get reads through a registered OR tree over all cells, with a
// register stage every four tree levels counted from the leaves and at the
// root (RD_LAT register stages); no new request is accepted until its result
// has been loaded into the output register.
// The output register lets a new request be accepted while a result waits, as
// long as the output is not stalled with a result already held.
// When the receiver stalls, the result holds and the input is stalled in turn.
// Reset empties the list (count zero) and clears the output valid; entry data
// is not cleared, since entries at or above the count are never read.
`default_nettype none

module indexed_list_insert_delete_get_unit #(
  parameter int CAPACITY = 256
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [1:0]         req_type_i,
  input  wire  signed [9:0]  position_i,
  input  wire  signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         status_o,
  output logic [8:0]         entry_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = ilist_pkg::AT_W;
  localparam int DW = ilist_pkg::DATA_W;
  localparam int RD_LAT = ilist_pkg::tree_latency($clog2(CAPACITY));
  localparam int CNT_W = $clog2(RD_LAT + 1);

  ilist_pkg::state_e     state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]         rd_pos_q, rd_pos_d;
  logic                  out_valid_q, out_valid_d;
  logic [DW-1:0]         read_value_q, read_value_d;
  logic [1:0]            status_q, status_d;
  logic [8:0]            entry_count_q;
  logic                  load_out;
  logic                  out_free;
  logic                  accept;
  logic                  pos_neg;
  logic [AW-1:0]         pos_u;
  logic [AW-1:0]         cnt_w;
  logic                  full;
  ilist_pkg::cell_ctrl_t ctrl;
  logic [DW-1:0]         cell_data [CAPACITY];
  logic [DW-1:0]         cell_rd [CAPACITY];
  logic [DW-1:0]         tree_root;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_w;
    logic [DW-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = item_value_i;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end
    ilist_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (item_value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  ilist_rd_tree #(
    .N(CAPACITY)
  ) u_rd_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_rd),
    .root_o (tree_root)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ilist_pkg::S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign pos_neg    = position_i[9];
  assign pos_u      = AW'(position_i[8:0]);
  assign cnt_w      = AW'(count_q);
  assign full       = (count_q == CW'(CAPACITY));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cnt_d        = cnt_q;
    rd_pos_d     = rd_pos_q;
    load_out     = 1'b0;
    read_value_d = '0;
    status_d     = ilist_pkg::ST_DONE;
    ctrl.ins     = 1'b0;
    ctrl.del     = 1'b0;
    ctrl.at      = pos_u;
    ctrl.rd_at   = rd_pos_q;
    case (state_q)
      ilist_pkg::S_IDLE: begin
        if (accept) begin
          case (ilist_pkg::req_e'(req_type_i))
            ilist_pkg::REQ_GET: begin
              if (pos_neg || (pos_u >= cnt_w)) begin
                load_out = 1'b1;
                status_d = ilist_pkg::ST_RANGE;
              end else begin
                state_d  = ilist_pkg::S_READ;
                rd_pos_d = pos_u;
                cnt_d    = '0;
              end
            end
            ilist_pkg::REQ_INSERT: begin
              load_out = 1'b1;
              if (!pos_neg && (pos_u > cnt_w)) begin
                status_d = ilist_pkg::ST_RANGE;
              end else if (full) begin
                status_d = ilist_pkg::ST_FULL;
              end else begin
                ctrl.ins = 1'b1;
                ctrl.at  = pos_neg ? '0 : pos_u;
                count_d  = count_q + CW'(1);
              end
            end
            ilist_pkg::REQ_TAIL: begin
              load_out = 1'b1;
              if (full) begin
                status_d = ilist_pkg::ST_FULL;
              end else begin
                ctrl.ins = 1'b1;
                ctrl.at  = cnt_w;
                count_d  = count_q + CW'(1);
              end
            end
            ilist_pkg::REQ_DELETE: begin
              load_out = 1'b1;
              if (pos_neg || (pos_u >= cnt_w)) begin
                status_d = ilist_pkg::ST_RANGE;
              end else begin
                ctrl.del = 1'b1;
                count_d  = count_q - CW'(1);
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ilist_pkg::S_READ: begin
        if (cnt_q == CNT_W'(RD_LAT)) begin
          if (out_free) begin
            load_out     = 1'b1;
            read_value_d = tree_root;
            state_d      = ilist_pkg::S_IDLE;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = ilist_pkg::S_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ilist_pkg::S_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= rd_pos_d;
    if (load_out) begin
      read_value_q  <= read_value_d;
      status_q      <= status_d;
      entry_count_q <= 9'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;

endmodule

`default_nettype wire

### tb/indexed_list_insert_delete_get_unit_tb.sv
module indexed_list_insert_delete_get_unit_tb;

  localparam int LIST_CAP = 256;

  typedef struct {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [8:0]         entry_count;
  } list_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i = ilist_pkg::REQ_GET;
  logic signed [9:0]  position_i = '0;
  logic signed [31:0] item_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] read_value_o;
  logic [1:0]         status_o;
  logic [8:0]         entry_count_o;

  logic signed [31:0] list_mem [LIST_CAP];
  int unsigned        list_len = 0;
  list_result_t       pending_results [$];
  int                 mismatch_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 receiver_hold_cycles = 0;

  indexed_list_insert_delete_get_unit #(
    .CAPACITY(LIST_CAP)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("indexed_list_insert_delete_get_unit: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void apply_request(input ilist_pkg::req_e kind,
                                        input logic signed [9:0] pos,
                                        input logic signed [31:0] val);
    list_result_t res;
    int p;
    int unsigned at;
    p = pos;
    res.read_value = '0;
    res.status = ilist_pkg::ST_DONE;
    case (kind)
      ilist_pkg::REQ_GET: begin
        if (p < 0 || p >= int'(list_len)) begin
          res.status = ilist_pkg::ST_RANGE;
        end else begin
          res.read_value = list_mem[p];
        end
      end
      ilist_pkg::REQ_INSERT, ilist_pkg::REQ_TAIL: begin
        if (kind == ilist_pkg::REQ_INSERT && p > int'(list_len)) begin
          res.status = ilist_pkg::ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          res.status = ilist_pkg::ST_FULL;
        end else begin
          if (kind == ilist_pkg::REQ_TAIL) begin
            at = list_len;
          end else begin
            at = (p < 0) ? 0 : p;
          end
          for (int unsigned i = list_len; i > at; i--) begin
            list_mem[i] = list_mem[i - 1];
          end
          list_mem[at] = val;
          list_len++;
        end
      end
      default: begin
        if (p < 0 || p >= int'(list_len)) begin
          res.status = ilist_pkg::ST_RANGE;
        end else begin
          for (int unsigned i = p; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i + 1];
          end
          list_len--;
        end
      end
    endcase
    res.entry_count = list_len[8:0];
    pending_results.push_back(res);
  endfunction

  task automatic send_request(input ilist_pkg::req_e kind, input logic signed [9:0] pos,
                              input logic signed [31:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    position_i   <= pos;
    item_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_request(kind, pos, val);
  endtask

  task automatic send_random_request(input int ins_weight, input int del_weight);
    int r;
    ilist_pkg::req_e kind;
    logic signed [9:0] pos;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_request(ilist_pkg::req_e'($urandom_range(0, 3)), 10'($urandom), $urandom);
    end else begin
      r = $urandom_range(0, 29 + ins_weight + ins_weight / 2 + del_weight);
      if (r < 30) begin
        kind = ilist_pkg::REQ_GET;
      end else if (r < 30 + ins_weight) begin
        kind = ilist_pkg::REQ_INSERT;
      end else if (r < 30 + ins_weight + ins_weight / 2) begin
        kind = ilist_pkg::REQ_TAIL;
      end else begin
        kind = ilist_pkg::REQ_DELETE;
      end
      if ($urandom_range(0, 99) < 15) begin
        pos = 10'($urandom);
      end else if (kind == ilist_pkg::REQ_INSERT) begin
        pos = 10'($urandom_range(0, list_len));
      end else if (list_len == 0) begin
        pos = '0;
      end else begin
        pos = 10'($urandom_range(0, list_len - 1));
      end
      send_request(kind, pos, $urandom);
    end
  endtask

  task automatic test_directed();
    send_request(ilist_pkg::REQ_GET, 10'sd0, 32'sd0);
    send_request(ilist_pkg::REQ_DELETE, 10'sd0, 32'sd0);
    send_request(ilist_pkg::REQ_GET, -10'sd512, $urandom);
    send_request(ilist_pkg::REQ_INSERT, 10'sd1, 32'sd5);
    send_request(ilist_pkg::REQ_TAIL, 10'sd0, 32'sh7fffffff);
    send_request(ilist_pkg::REQ_INSERT, -10'sd512, 32'sh80000000);
    send_request(ilist_pkg::REQ_INSERT, 10'sd2, -32'sd1);
    send_request(ilist_pkg::REQ_INSERT, 10'sd1, 32'sd0);
    send_request(ilist_pkg::REQ_GET, 10'sd0, $urandom);
    send_request(ilist_pkg::REQ_GET, 10'sd3, 32'sd0);
    send_request(ilist_pkg::REQ_GET, 10'sd4, 32'sd0);
    send_request(ilist_pkg::REQ_GET, -10'sd1, 32'sd0);
    send_request(ilist_pkg::REQ_GET, 10'sd511, 32'sd0);
    send_request(ilist_pkg::REQ_DELETE, 10'sd511, 32'sd0);
    send_request(ilist_pkg::REQ_DELETE, -10'sd1, 32'sd0);
    send_request(ilist_pkg::REQ_DELETE, 10'sd3, $urandom);
    send_request(ilist_pkg::REQ_DELETE, 10'sd0, 32'sd0);
    send_request(ilist_pkg::REQ_INSERT, 10'sd511, 32'sd9);
    send_request(ilist_pkg::REQ_TAIL, -10'sd512, 32'sh55555555);
    send_request(ilist_pkg::REQ_GET, 10'sd2, 32'sd0);
    send_request(ilist_pkg::REQ_INSERT, -10'sd1, 32'shaaaaaaaa);
    send_request(ilist_pkg::REQ_GET, 10'sd0, 32'sd0);
    send_request(ilist_pkg::REQ_DELETE, 10'sd1, 32'sd0);
    send_request(ilist_pkg::REQ_GET, 10'sd1, 32'sd0);
  endtask

  task automatic test_fill_and_drain();
    while (list_len < LIST_CAP) begin
      if ($urandom_range(0, 99) < 70) begin
        send_request(ilist_pkg::REQ_TAIL, 10'($urandom), $urandom);
      end else begin
        send_request(ilist_pkg::REQ_INSERT, 10'($urandom_range(0, list_len)), $urandom);
      end
    end
    send_request(ilist_pkg::REQ_INSERT, 10'sd0, $urandom);
    send_request(ilist_pkg::REQ_TAIL, 10'sd0, $urandom);
    send_request(ilist_pkg::REQ_INSERT, -10'sd512, $urandom);
    send_request(ilist_pkg::REQ_INSERT, 10'sd256, $urandom);
    send_request(ilist_pkg::REQ_INSERT, 10'sd257, $urandom);
    send_request(ilist_pkg::REQ_INSERT, 10'sd511, $urandom);
    send_request(ilist_pkg::REQ_GET, 10'sd255, 32'sd0);
    send_request(ilist_pkg::REQ_GET, 10'sd256, 32'sd0);
    send_request(ilist_pkg::REQ_DELETE, 10'sd256, 32'sd0);
    send_request(ilist_pkg::REQ_DELETE, 10'sd255, 32'sd0);
    send_request(ilist_pkg::REQ_TAIL, 10'sd0, $urandom);
    while (list_len > 0) begin
      if ($urandom_range(0, 99) < 20) begin
        send_request(ilist_pkg::REQ_GET, 10'($urandom_range(0, list_len - 1)), $urandom);
      end else begin
        send_request(ilist_pkg::REQ_DELETE, 10'($urandom_range(0, list_len - 1)), $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    receiver_hold_cycles = 100;
    repeat (30) send_random_request(30, 30);
  endtask

  task automatic test_random(input int num_items);
    int ins_w;
    int del_w;
    int phase;
    for (int n = 0; n < num_items; n++) begin
      if (n % 50 == 0) begin
        phase = $urandom_range(0, 2);
        ins_w = (phase == 0) ? 50 : (phase == 1) ? 10 : 30;
        del_w = (phase == 0) ? 10 : (phase == 1) ? 50 : 30;
      end
      send_random_request(ins_w, del_w);
    end
  endtask

  always @(posedge clk_i) begin
    if (receiver_hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      receiver_hold_cycles <= receiver_hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        exp_res = pending_results.pop_front();
        if (read_value_o !== exp_res.read_value) begin
          report_mismatch($sformatf("read_value %h, expected %h",
                                    read_value_o, exp_res.read_value));
        end
        if (status_o !== exp_res.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status_o, exp_res.status));
        end
        if (entry_count_o !== exp_res.entry_count) begin
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    entry_count_o, exp_res.entry_count));
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 29;
    recv_idle_pct = 73;
    test_directed();
    test_random(300);

    send_idle_pct = 73;
    recv_idle_pct = 29;
    test_fill_and_drain();
    test_random(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(250);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("indexed_list_insert_delete_get_unit: match");
    end else begin
      $display("indexed_list_insert_delete_get_unit: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ilist_pkg.sv
hw/rtl/ilist_cell.sv
hw/rtl/ilist_rd_tree.sv
hw/rtl/indexed_list_insert_delete_get_unit.sv
tb/indexed_list_insert_delete_get_unit_tb.sv
